// ----- rtl/core/isrs_pkg.sv -----
`timescale 1ns / 1ps

package isrs_pkg;

    // field widths
    localparam int PULSE_W = 16;
    localparam int DAC_W   = 12;
    localparam int STEP_W  = 8;
    localparam int CMD_W   = 3;

    // sine table geometry
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH_FLOOR  = 3'd0;
    localparam logic [2:0] REG_WIDTH_CEIL   = 3'd1;
    localparam logic [2:0] REG_WIDTH_OFFSET = 3'd2;
    localparam logic [2:0] REG_LAST_INDEX   = 3'd3;
    localparam logic [2:0] REG_DEAD_START   = 3'd4;

    // configuration reset values
    localparam logic [PULSE_W-1:0] WIDTH_FLOOR_RST  = 16'd0;
    localparam logic [PULSE_W-1:0] WIDTH_CEIL_RST   = 16'hFFFF;
    localparam logic [PULSE_W-1:0] WIDTH_OFFSET_RST = 16'd0;
    localparam logic [STEP_W-1:0]  LAST_INDEX_RST   = 8'd255;
    localparam logic [STEP_W-1:0]  DEAD_START_RST   = 8'd240;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_CAPT_A    = 3'd1,
        CMD_CAPT_B    = 3'd2,
        CMD_MASTER    = 3'd3,
        CMD_START     = 3'd4,
        CMD_STOP      = 3'd5,
        CMD_LOAD      = 3'd6
    } cmd_t;

    // output levels
    typedef struct packed {
        logic pin_two;
        logic pin_one;
        logic drv;
        logic out_c;
        logic out_a;
    } levels_t;

endpackage

// ----- rtl/core/inverter_sine_reference_sequencer_unit.sv -----
`timescale 1ns / 1ps
// timing: a result is registered and valid in the cycle after its input transaction is accepted
// throughput: one item per cycle while the result stream is not stalled; the sine entry for the current step is fetched
// ahead from the next step index through the table's registered read port
// reset: all sequencer state, compares, dac and configuration return to defaults;
// the sine table is not cleared and must be loaded before ticks read it

module inverter_sine_reference_sequencer_unit
    import isrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [PULSE_W-1:0]    cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // captured_count, table_index, table_value
    input  logic [CMD_W-1:0]      s_tuser,   // command
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // out_a_enable, out_c_enable, driver_enable,
                                             // line_pin_one, line_pin_two, polarity, dac_code,
                                             // dac_strobe, compare_a, compare_c
);

    // configuration
    logic [PULSE_W-1:0] min_reg, max_reg, delta_reg;
    logic [STEP_W-1:0]  last_reg, dead_reg;

    // sequencer state (pulse A width is never observed apart from compare A, so not kept)
    logic               toggle_reg, toggle_next;
    logic               half_reg, half_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PULSE_W-1:0] pulse_b_reg, pulse_b_next;
    levels_t            lv_reg, lv_next;
    logic [DAC_W-1:0]   dac_reg, dac_next;
    logic [PULSE_W-1:0] cmp_a_reg, cmp_a_next;
    logic [PULSE_W-1:0] cmp_c_reg, cmp_c_next;
    logic               strobe;

    // result register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // table access
    logic [DAC_W-1:0]  tbl_rd_data;
    logic              byp_hit_reg;
    logic [DAC_W-1:0]  byp_data_reg;
    logic [DAC_W-1:0]  tbl_entry;
    logic              tbl_wr_en;
    logic [TBL_AW-1:0] tbl_rd_addr;

    // input fields
    cmd_t               cmd;
    logic [PULSE_W-1:0] capt_count;
    logic [STEP_W-1:0]  tbl_index;
    logic [DAC_W-1:0]   tbl_value;
    logic               in_acc;

    // capture clamp
    logic [PULSE_W:0]   diff;
    logic [PULSE_W-1:0] capt_hi, capt_clamped;

    assign cmd        = cmd_t'(s_tuser);
    assign capt_count = s_tdata[15:0];
    assign tbl_index  = s_tdata[23:16];
    assign tbl_value  = s_tdata[35:24];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= WIDTH_FLOOR_RST;
            max_reg   <= WIDTH_CEIL_RST;
            delta_reg <= WIDTH_OFFSET_RST;
            last_reg  <= LAST_INDEX_RST;
            dead_reg  <= DEAD_START_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH_FLOOR:  min_reg   <= cfg_data;
                REG_WIDTH_CEIL:   max_reg   <= cfg_data;
                REG_WIDTH_OFFSET: delta_reg <= cfg_data;
                REG_LAST_INDEX:   last_reg  <= cfg_data[STEP_W-1:0];
                REG_DEAD_START:   dead_reg  <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // sine table, read address runs one item ahead
    assign tbl_wr_en   = in_acc && (cmd == CMD_LOAD);
    assign tbl_rd_addr = step_next[TBL_AW-1:0];

    isrs_ram #(
        .WIDTH (DAC_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_index[TBL_AW-1:0]),
        .wr_data (tbl_value),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // forward a load that hit the address being prefetched
    always_ff @(posedge clk)
    begin
        byp_hit_reg  <= tbl_wr_en && (tbl_index[TBL_AW-1:0] == tbl_rd_addr);
        byp_data_reg <= tbl_value;
    end

    assign tbl_entry = byp_hit_reg ? byp_data_reg : tbl_rd_data;

    // capture clamp: underflow saturates high, max applied before min
    always_comb
    begin
        diff         = {1'b0, capt_count} - {1'b0, delta_reg};
        capt_hi      = (diff[PULSE_W] || (diff[PULSE_W-1:0] > max_reg)) ? max_reg
                                                                       : diff[PULSE_W-1:0];
        capt_clamped = (capt_hi < min_reg) ? min_reg : capt_hi;
    end

    // next state per command
    always_comb
    begin
        toggle_next  = toggle_reg;
        half_next    = half_reg;
        step_next    = step_reg;
        pulse_b_next = pulse_b_reg;
        lv_next      = lv_reg;
        dac_next     = dac_reg;
        cmp_a_next   = cmp_a_reg;
        cmp_c_next   = cmp_c_reg;
        strobe       = 1'b0;

        if (in_acc)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    strobe        = 1'b1;
                    toggle_next   = !toggle_reg;
                    lv_next.out_a = !toggle_reg;
                    // start of a wave
                    if (step_reg == '0)
                    begin
                        cmp_a_next    = min_reg;
                        cmp_c_next    = min_reg;
                        pulse_b_next  = min_reg;
                        toggle_next   = 1'b0;
                        lv_next.drv   = 1'b1;
                        lv_next.out_a = 1'b1;
                        lv_next.out_c = 1'b1;
                        half_next     = !half_reg;
                        lv_next.pin_one = half_reg;
                        lv_next.pin_two = !half_reg;
                    end
                    // dead time blanking
                    if (step_reg >= dead_reg)
                    begin
                        dac_next        = '0;
                        lv_next         = '0;
                    end
                    else
                    begin
                        dac_next = tbl_entry;
                    end
                    step_next = (step_reg >= last_reg) ? '0 : step_reg + 1'b1;
                end
                CMD_CAPT_A:
                begin
                    pulse_b_next = capt_clamped;
                end
                CMD_CAPT_B:
                begin
                    pulse_b_next = max_reg;
                    cmp_a_next   = max_reg;
                end
                CMD_MASTER:
                begin
                    cmp_c_next = pulse_b_reg;
                end
                CMD_START:
                begin
                    toggle_next = 1'b0;
                    step_next   = '0;
                    half_next   = 1'b0;
                    lv_next     = '{pin_two: 1'b0, pin_one: 1'b0, drv: 1'b1,
                                    out_c: 1'b1, out_a: 1'b1};
                end
                CMD_STOP:
                begin
                    toggle_next = 1'b0;
                    step_next   = '0;
                    half_next   = 1'b0;
                    lv_next     = '0;
                    dac_next    = '0;
                    strobe      = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        m_tdata_next = {5'd0, cmp_c_next, cmp_a_next, strobe, dac_next, half_next,
                        lv_next.pin_two, lv_next.pin_one, lv_next.drv,
                        lv_next.out_c, lv_next.out_a};
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg  <= 1'b0;
            half_reg    <= 1'b0;
            step_reg    <= '0;
            pulse_b_reg <= WIDTH_FLOOR_RST;
            lv_reg      <= '0;
            dac_reg     <= '0;
            cmp_a_reg   <= '0;
            cmp_c_reg   <= '0;
        end
        else
        begin
            toggle_reg  <= toggle_next;
            half_reg    <= half_next;
            step_reg    <= step_next;
            pulse_b_reg <= pulse_b_next;
            lv_reg      <= lv_next;
            dac_reg     <= dac_next;
            cmp_a_reg   <= cmp_a_next;
            cmp_c_reg   <= cmp_c_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef SYNTHESIS
    // line pins never drive both polarities
    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(lv_reg.pin_one && lv_reg.pin_two))
        else $error("both line pins high");

    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid_reg)
        else $error("input stalled with empty result register");

    // a stop shuts the driver and strobes a zero dac code
    a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == CMD_STOP)) |=>
            (m_tvalid_reg && !m_tdata_reg[2] && m_tdata_reg[18] && (m_tdata_reg[17:6] == '0)))
        else $error("stop result wrong");

    // a tick at the wave start outside dead time arms the driver
    a_wave_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == CMD_TICK) && (step_reg == '0) && (dead_reg != '0)) |=>
            (lv_reg.drv && lv_reg.out_a && lv_reg.out_c))
        else $error("wave start did not enable driver");
`endif

endmodule

// ----- rtl/core/isrs_ram.sv -----
`timescale 1ns / 1ps

module isrs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read (old data on collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
